// ===== rtl/etur_pkg.sv =====
package etur_pkg;

  // Request codes as they arrive on the input channel
  localparam logic [1:0] REQ_EDGE = 2'd0;
  localparam logic [1:0] REQ_POLL = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // Configuration register indexes
  localparam logic CFG_IDX_BPT    = 1'b0;
  localparam logic CFG_IDX_DIRECT = 1'b1;

  localparam logic [7:0] BPT_RESET   = 8'd39;
  localparam logic [7:0] EDGE_SLACK  = 8'd4;
  localparam logic [3:0] FRAME_SLOTS = 4'd9;
  localparam logic [7:0] FIRST_MASK  = 8'h01;

  typedef enum logic [1:0] {
    CMD_EDGE,
    CMD_POLL,
    CMD_READ,
    CMD_NOP
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tick;
    logic       level;
  } q_item_t;

  typedef struct packed {
    logic [7:0] bpt;
    logic       direct;
  } cfg_t;

endpackage

// ===== rtl/etur_front.sv =====
module etur_front import etur_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_tick_time,
  input  logic       in_line_level,
  output logic       q_valid,
  output q_item_t    q_head,
  input  logic       q_pop
);

  q_item_t    q_mem_r [2];
  logic       wr_idx_r;
  logic       rd_idx_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       push;
  q_item_t    item_in;

  function automatic cmd_t classify(logic [1:0] req);
    cmd_t c;
    case (req)
      REQ_EDGE: c = CMD_EDGE;
      REQ_POLL: c = CMD_POLL;
      REQ_READ: c = CMD_READ;
      default:  c = CMD_NOP;
    endcase
    return c;
  endfunction

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_head   = q_mem_r[rd_idx_r];
  assign cnt_nxt  = cnt_r + 2'(push) - 2'(q_pop);

  always_comb begin
    item_in.cmd   = classify(in_req_type);
    item_in.tick  = in_tick_time;
    item_in.level = in_line_level;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= 1'b0;
      rd_idx_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_idx_r <= ~wr_idx_r;
      end
      if (q_pop) begin
        rd_idx_r <= ~rd_idx_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_idx_r] <= item_in;
    end
  end

endmodule

// ===== rtl/etur_back.sv =====
module etur_back import etur_pkg::*; #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  q_item_t    q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_byte_valid,
  output logic [7:0] out_data_byte,
  output logic       out_char_completed,
  output logic       out_overflow_drop,
  output logic [5:0] out_buffer_count
);

  localparam int PW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [PW-1:0] LAST_SLOT = PW'(BUFFER_DEPTH - 1);

  typedef enum logic {B_TAKE, B_EXEC} bstate_t;

  bstate_t    st_r;
  q_item_t    item_r;
  logic [5:0] nbits_r;
  logic [7:0] rd_data_r;
  logic       idle_r, idle_nxt;
  logic [3:0] br_r, br_nxt;
  logic [7:0] last_r, last_nxt;
  logic [7:0] mask_r, mask_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt, wp_inc, rp_inc;
  logic       out_valid_r;
  logic       ob_valid_r, ob_done_r, ob_drop_r;
  logic [7:0] ob_data_r;
  logic [5:0] ob_count_r;

  logic [7:0] ring_mem [BUFFER_DEPTH];

  logic [7:0]  delta;
  logic [15:0] product;
  logic [3:0]  left, take, br_sum;
  logic        next_started;
  logic [15:0] run_take, run_left;
  logic [7:0]  hi_mask, done_byte;
  logic        deliver, wr_en, exec_go;
  logic        ob_valid, ob_done, ob_drop;
  logic [7:0]  ob_data;
  logic [PW:0] cnt;
  logic [PW+6:0] cnt_ext;

  // Set n bits from the mask position upward; return {ones, advanced mask}
  function automatic logic [15:0] fill_run(logic [7:0] mask, logic [3:0] n);
    logic [16:0] hi;
    logic [16:0] diff;
    hi   = {9'b0, mask} << n;
    diff = hi - {9'b0, mask};
    return {diff[7:0], hi[7:0]};
  endfunction

  // Elapsed bit periods: one 8x8 multiply, registered on the take cycle
  assign delta   = q_head.tick - last_r + EDGE_SLACK;
  assign product = {8'b0, delta} * {8'b0, cfg.bpt};

  assign q_pop   = (st_r == B_TAKE) && q_valid;
  assign exec_go = (st_r == B_EXEC) && (!out_valid_r || !out_stall);
  assign wp_inc  = (wp_r == LAST_SLOT) ? '0 : wp_r + 1'b1;
  assign rp_inc  = (rp_r == LAST_SLOT) ? '0 : rp_r + 1'b1;

  always_comb begin
    idle_nxt  = idle_r;
    br_nxt    = br_r;
    last_nxt  = last_r;
    mask_nxt  = mask_r;
    byte_nxt  = byte_r;
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    deliver   = 1'b0;
    wr_en     = 1'b0;
    ob_valid  = 1'b0;
    ob_data   = 8'd0;
    ob_done   = 1'b0;
    ob_drop   = 1'b0;
    done_byte = byte_r;
    hi_mask   = mask_r;
    left         = FRAME_SLOTS - {1'b0, br_r[2:0]};
    next_started = nbits_r > {2'b00, left};
    take         = next_started ? left : nbits_r[3:0];
    br_sum       = {1'b0, br_r[2:0]} + take;
    run_take     = fill_run(mask_r, take);
    run_left     = fill_run(mask_r, left);

    case (item_r.cmd)
      CMD_EDGE: begin
        if (idle_r) begin
          if (!item_r.level) begin
            idle_nxt = 1'b0;
            br_nxt   = 4'd0;
            mask_nxt = FIRST_MASK;
            byte_nxt = 8'd0;
            last_nxt = item_r.tick;
          end
        end else begin
          br_nxt = br_sum;
          if (!item_r.level) begin
            done_byte = byte_r | run_take[15:8];
            mask_nxt  = {run_take[6:0], 1'b0};
          end else begin
            if (take != 4'd0) begin
              hi_mask = mask_r << (take - 4'd1);
            end
            mask_nxt  = hi_mask;
            done_byte = byte_r | hi_mask;
          end
          byte_nxt = done_byte;
          if (br_sum > 4'd7) begin
            deliver = 1'b1;
            idle_nxt = item_r.level || !next_started;
            br_nxt   = 4'd0;
            if (!item_r.level && next_started) begin
              mask_nxt = FIRST_MASK;
              byte_nxt = 8'd0;
            end
          end
          last_nxt = item_r.tick;
        end
      end
      CMD_POLL: begin
        if (wp_r == rp_r && !idle_r && item_r.level && nbits_r > {2'b00, left}) begin
          done_byte = byte_r | run_left[15:8];
          byte_nxt  = done_byte;
          mask_nxt  = run_left[7:0];
          deliver   = 1'b1;
          idle_nxt  = 1'b1;
          br_nxt    = 4'd0;
        end
      end
      CMD_READ: begin
        if (wp_r != rp_r) begin
          ob_valid = 1'b1;
          ob_data  = rd_data_r;
          rp_nxt   = rp_inc;
        end
      end
      default: begin
      end
    endcase

    if (deliver) begin
      ob_done = 1'b1;
      if (cfg.direct) begin
        ob_valid = 1'b1;
        ob_data  = done_byte;
      end else if (wp_inc != rp_r) begin
        wr_en  = 1'b1;
        wp_nxt = wp_inc;
      end else begin
        ob_drop = 1'b1;
      end
    end

    if (wp_nxt >= rp_nxt) begin
      cnt = {1'b0, wp_nxt} - {1'b0, rp_nxt};
    end else begin
      cnt = {1'b0, wp_nxt} + (PW+1)'(BUFFER_DEPTH) - {1'b0, rp_nxt};
    end
    cnt_ext = {6'b0, cnt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_TAKE;
      out_valid_r <= 1'b0;
      idle_r      <= 1'b1;
      br_r        <= 4'd0;
      last_r      <= 8'd0;
      mask_r      <= FIRST_MASK;
      byte_r      <= 8'd0;
      wp_r        <= '0;
      rp_r        <= '0;
    end else begin
      if (exec_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        B_TAKE: begin
          if (q_valid) begin
            item_r  <= q_head;
            nbits_r <= product[15:10];
            st_r    <= B_EXEC;
          end
        end
        B_EXEC: begin
          if (exec_go) begin
            idle_r      <= idle_nxt;
            br_r        <= br_nxt;
            last_r      <= last_nxt;
            mask_r      <= mask_nxt;
            byte_r      <= byte_nxt;
            wp_r        <= wp_nxt;
            rp_r        <= rp_nxt;
            ob_valid_r  <= ob_valid;
            ob_data_r   <= ob_data;
            ob_done_r   <= ob_done;
            ob_drop_r   <= ob_drop;
            ob_count_r  <= cnt_ext[5:0];
            st_r        <= B_TAKE;
          end
        end
        default: st_r <= B_TAKE;
      endcase
    end
  end

  // Ring storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (exec_go && wr_en) begin
      ring_mem[wp_r] <= done_byte;
    end
    if (q_pop) begin
      rd_data_r <= ring_mem[rp_r];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte_valid     = ob_valid_r;
  assign out_data_byte      = ob_data_r;
  assign out_char_completed = ob_done_r;
  assign out_overflow_drop  = ob_drop_r;
  assign out_buffer_count   = ob_count_r;

endmodule

// ===== rtl/edge_timed_uart_receiver.sv =====
// Channel   Direction  Handshake          Beat contents
// in_*      input      in_valid/in_stall  req_type, tick_time, line_level
// out_*     output     out_valid/out_stall byte_valid, data_byte, char_completed,
//                                         overflow_drop, buffer_count
// cfg_*     input      cfg_we             cfg_index, cfg_wdata (no read-back)
//
// In the back end each beat goes through a take cycle (pop from the
// two-entry queue, 8x8 elapsed-bit multiply, ring read) and an execute cycle.
// Reset is synchronous, active low; the ring has no clearing pass and its
// contents stay undefined until written. The execute cycle holds while a
// result waits in the output register under out_stall; the front queue keeps
// accepting beats meanwhile until both of its entries are full.
module edge_timed_uart_receiver import etur_pkg::*; #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_tick_time,
  input  logic       in_line_level,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_byte_valid,
  output logic [7:0] out_data_byte,
  output logic       out_char_completed,
  output logic       out_overflow_drop,
  output logic [5:0] out_buffer_count,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata
);

  logic [7:0] bpt_r;
  logic       direct_r;
  cfg_t       cfg;
  logic       q_valid;
  logic       q_pop;
  q_item_t    q_head;

  // Configuration registers; receive state is left alone on a write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpt_r    <= BPT_RESET;
      direct_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_BPT:    bpt_r    <= cfg_wdata;
        CFG_IDX_DIRECT: direct_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.bpt    = bpt_r;
  assign cfg.direct = direct_r;

  // Front: classify the request and hold it in a short queue
  etur_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_tick_time  (in_tick_time),
    .in_line_level (in_line_level),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop)
  );

  // Back: frame tracking, ring and the output register
  etur_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .q_valid            (q_valid),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte_valid     (out_byte_valid),
    .out_data_byte      (out_data_byte),
    .out_char_completed (out_char_completed),
    .out_overflow_drop  (out_overflow_drop),
    .out_buffer_count   (out_buffer_count)
  );

  // Never pop an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // A dropped byte is a completed byte that went nowhere
  a_drop_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow_drop |-> out_char_completed && !out_byte_valid)
    else $error("overflow drop without a completed, undelivered byte");

  // The input side only frees up after the back end drained an entry
  a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(in_stall) |-> $past(q_pop))
    else $error("input stall released without a queue pop");

endmodule

// ===== bench/edge_timed_uart_receiver_tb.sv =====
`timescale 1ns / 1ps

module edge_timed_uart_receiver_tb;
  import etur_pkg::*;

  // One result beat as the block reports it
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       char_completed;
    logic       overflow_drop;
    logic [5:0] buffer_count;
  } rx_result_t;

  // Tracks the receive frame, the byte ring and the registers, and holds the
  // result beats still owed by the block, oldest first.
  class uart_rx_tracker;
    logic [7:0] bpt;
    logic       direct;
    logic [7:0] ring [64];
    logic [5:0] wr_ptr;
    logic [5:0] rd_ptr;
    logic       frame_idle;
    logic [3:0] bit_count;
    logic [7:0] last_tick;
    logic [7:0] mask;
    logic [7:0] shreg;
    rx_result_t results_due[$];
    int         errors;

    function new();
      bpt        = BPT_RESET;
      direct     = 1'b0;
      wr_ptr     = '0;
      rd_ptr     = '0;
      frame_idle = 1'b1;
      bit_count  = '0;
      last_tick  = '0;
      mask       = FIRST_MASK;
      shreg      = '0;
      errors     = 0;
      foreach (ring[i]) ring[i] = '0;
    endfunction

    function void set_reg(logic idx, logic [7:0] val);
      if (idx == CFG_IDX_BPT) bpt = val;
      else direct = val[0];
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    // Whole bit periods since the last edge, with four ticks of slack
    function int unsigned bits_since(logic [7:0] now);
      logic [7:0]  d;
      logic [15:0] p;
      d = now - last_tick + EDGE_SLACK;
      p = d * bpt;
      return p[15:10];
    endfunction

    function void shift_in_ones(int unsigned n);
      repeat (n) begin
        shreg = shreg | mask;
        mask  = mask << 1;
      end
    endfunction

    function void restart();
      frame_idle = 1'b0;
      bit_count  = '0;
      mask       = FIRST_MASK;
      shreg      = '0;
    endfunction

    function void hand_off(inout rx_result_t r);
      r.char_completed = 1'b1;
      if (direct) begin
        r.byte_valid = 1'b1;
        r.data_byte  = shreg;
      end else if (6'(wr_ptr + 6'd1) != rd_ptr) begin
        ring[wr_ptr] = shreg;
        wr_ptr       = wr_ptr + 6'd1;
      end else begin
        r.overflow_drop = 1'b1;
      end
    endfunction

    function void take_request(logic [1:0] req, logic [7:0] tick, logic level);
      rx_result_t  r;
      int unsigned nb;
      int unsigned room;
      int unsigned take;
      logic        spill;
      r = '0;
      case (req)
        REQ_EDGE: begin
          if (frame_idle) begin
            if (!level) begin
              restart();
              last_tick = tick;
            end
          end else begin
            nb        = bits_since(tick);
            room      = FRAME_SLOTS - bit_count[2:0];
            spill     = nb > room;
            take      = spill ? room : nb;
            bit_count = 4'(bit_count[2:0] + take);
            if (!level) begin
              shift_in_ones(take);
              mask = mask << 1;
            end else begin
              if (take > 0) mask = mask << (take - 1);
              shreg = shreg | mask;
            end
            if (bit_count > 4'd7) begin
              hand_off(r);
              if (level || !spill) begin
                frame_idle = 1'b1;
                bit_count  = '0;
              end else begin
                restart();
              end
            end
            last_tick = tick;
          end
        end
        REQ_POLL: begin
          if (wr_ptr == rd_ptr && !frame_idle && level) begin
            room = FRAME_SLOTS - bit_count[2:0];
            if (bits_since(tick) > room) begin
              shift_in_ones(room);
              hand_off(r);
              frame_idle = 1'b1;
              bit_count  = '0;
            end
          end
        end
        REQ_READ: begin
          if (wr_ptr != rd_ptr) begin
            r.byte_valid = 1'b1;
            r.data_byte  = ring[rd_ptr];
            rd_ptr       = rd_ptr + 6'd1;
          end
        end
        default: ;
      endcase
      r.buffer_count = wr_ptr - rd_ptr;
      results_due.push_back(r);
    endfunction

    function void match_result(rx_result_t got);
      rx_result_t want;
      if (results_due.size() == 0) begin
        $error("result beat arrived with no request outstanding");
        errors++;
        return;
      end
      want = results_due.pop_front();
      if (got.byte_valid !== want.byte_valid) begin
        $error("byte_valid: expected %0d, got %0d", want.byte_valid, got.byte_valid);
        errors++;
      end
      if (got.data_byte !== want.data_byte) begin
        $error("data_byte: expected %02h, got %02h", want.data_byte, got.data_byte);
        errors++;
      end
      if (got.char_completed !== want.char_completed) begin
        $error("char_completed: expected %0d, got %0d", want.char_completed,
               got.char_completed);
        errors++;
      end
      if (got.overflow_drop !== want.overflow_drop) begin
        $error("overflow_drop: expected %0d, got %0d", want.overflow_drop,
               got.overflow_drop);
        errors++;
      end
      if (got.buffer_count !== want.buffer_count) begin
        $error("buffer_count: expected %0d, got %0d", want.buffer_count,
               got.buffer_count);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_req_type = REQ_EDGE;
  logic [7:0] in_tick_time = '0;
  logic       in_line_level = 1'b1;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_byte_valid;
  logic [7:0] out_data_byte;
  logic       out_char_completed;
  logic       out_overflow_drop;
  logic [5:0] out_buffer_count;
  logic       cfg_we = 1'b0;
  logic       cfg_index = CFG_IDX_BPT;
  logic [7:0] cfg_wdata = '0;

  uart_rx_tracker track = new();

  int         beats_sent = 0;
  int         cur_bpt = BPT_RESET;  // rate the frame builder times its edges with
  logic [7:0] tick_now = '0;        // free-running timer as the sender sees it
  bit         jitter_on = 1'b0;
  bit         paused = 1'b0;

  edge_timed_uart_receiver dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_tick_time       (in_tick_time),
    .in_line_level      (in_line_level),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte_valid     (out_byte_valid),
    .out_data_byte      (out_data_byte),
    .out_char_completed (out_char_completed),
    .out_overflow_drop  (out_overflow_drop),
    .out_buffer_count   (out_buffer_count),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Offer one beat and hold it until the block takes it. Idle now and then,
  // except over a long stretch in the middle of the run.
  task automatic send(input logic [1:0] req, input logic [7:0] tick, input logic level);
    if (!(beats_sent >= 1000 && beats_sent < 1300) && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 50);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_tick_time  <= tick;
    in_line_level <= level;
    do @(posedge clk); while (in_stall);
    track.take_request(req, tick, level);
    beats_sent++;
  endtask

  // Drop valid and hold until every owed result beat has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (track.pending() != 0);
  endtask

  // Ticks from the start bit to the leading edge of bit k at the current rate
  function automatic logic [7:0] bit_off(int k);
    return 8'((k * 1024) / cur_bpt);
  endfunction

  function automatic logic [7:0] wobble();
    if (!jitter_on || $urandom_range(4) != 0) return 8'd0;
    return $urandom_range(1) ? 8'd1 : 8'hFF;
  endfunction

  // Send one 8N1 character as line edges, LSB first. Stop after cut edges to
  // break the frame. A character whose top bits are ones only completes on a
  // poll or on the next start bit.
  task automatic play_frame(input logic [7:0] b, input bit poll_tail, input int cut);
    logic [7:0] t0;
    logic       lvl;
    logic       nl;
    int         edges;
    t0 = tick_now;
    send(REQ_EDGE, t0, 1'b0);
    lvl   = 1'b0;
    edges = 1;
    for (int k = 1; k <= 9; k++) begin
      nl = (k == 9) ? 1'b1 : b[k-1];
      if (nl != lvl && edges < cut) begin
        send(REQ_EDGE, t0 + bit_off(k) + wobble(), nl);
        edges++;
      end
      lvl = nl;
    end
    if (poll_tail && b[7] && edges < cut) send(REQ_POLL, t0 + bit_off(10) + 8'd2, 1'b1);
    tick_now = t0 + bit_off(10);
    if (jitter_on) tick_now = tick_now + 8'($urandom_range(bit_off(3)));
  endtask

  task automatic write_regs(input logic [7:0] bpt, input logic direct);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_BPT;
    cfg_wdata <= bpt;
    @(posedge clk);
    track.set_reg(CFG_IDX_BPT, bpt);
    cfg_index <= CFG_IDX_DIRECT;
    cfg_wdata <= {7'd0, direct};
    @(posedge clk);
    track.set_reg(CFG_IDX_DIRECT, {7'd0, direct});
    cfg_we  <= 1'b0;
    cur_bpt = bpt;
  endtask

  // Mostly well-formed characters with random content; the rest is reads,
  // broken frames and random noise beats.
  task automatic run_phase(input logic [7:0] bpt, input logic direct, input int n,
                           input int read_pct);
    int         stop_at;
    int         r;
    logic [7:0] b;
    write_regs(bpt, direct);
    stop_at = beats_sent + n;
    while (beats_sent < stop_at) begin
      // hold the sender once until the block has answered everything
      if (!paused && beats_sent >= 150) begin
        paused = 1'b1;
        wait_drained();
      end
      r = $urandom_range(99);
      if (r < 10) begin
        send(2'($urandom_range(3)), 8'($urandom), 1'($urandom));
      end else if (r < 10 + read_pct) begin
        send(REQ_READ, 8'($urandom), 1'($urandom));
      end else begin
        case ($urandom_range(7))
          0: b = 8'h00;
          1: b = 8'hFF;
          2, 3: b = 8'($urandom) | 8'h80;
          default: b = 8'($urandom);
        endcase
        play_frame(b, $urandom_range(99) < 70,
                   ($urandom_range(99) < 8) ? int'($urandom_range(9, 1)) : 99);
      end
    end
  endtask

  // Result side: check every beat taken, stall at random, and once hold off
  // for a long stretch so the block backs up into its input.
  initial begin
    int         seen;
    int         hold_left;
    bit         held;
    rx_result_t got;
    seen      = 0;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got = '{byte_valid: out_byte_valid, data_byte: out_data_byte,
                char_completed: out_char_completed, overflow_drop: out_overflow_drop,
                buffer_count: out_buffer_count};
        track.match_result(got);
        seen++;
      end
      if (seen == 400 && !held) begin
        held      = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (seen >= 800 && seen < 1100) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 12);
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Idle-state corners: empty read, unused code, high edge, poll
    send(REQ_READ, 8'h00, 1'b0);
    send(CMD_NOP, 8'hFF, 1'b1);
    send(REQ_EDGE, 8'hFF, 1'b1);
    send(REQ_POLL, 8'h00, 1'b1);

    // High edge at the same tick as the start bit: mask stays on bit 0
    send(REQ_EDGE, 8'd10, 1'b0);
    send(REQ_EDGE, 8'd10, 1'b1);
    send(REQ_EDGE, 8'd14, 1'b1);
    send(REQ_EDGE, 8'd14 + bit_off(9) + 8'd2, 1'b1);

    // Clean characters; the last low start bit lands right after a byte
    // that ended in ones, and one frame wraps the timer
    tick_now = 8'd40;
    play_frame(8'h0F, 1'b1, 99);
    play_frame(8'hF0, 1'b1, 99);
    tick_now = 8'd250;
    play_frame(8'h00, 1'b1, 99);
    play_frame(8'hFF, 1'b0, 99);
    play_frame(8'h3C, 1'b1, 99);

    // Late low edge: eight bits filled, mask runs off the top of the byte
    send(REQ_EDGE, tick_now, 1'b0);
    send(REQ_EDGE, tick_now + bit_off(8) + 8'd10, 1'b0);

    repeat (3) send(REQ_READ, 8'($urandom), 1'($urandom));

    jitter_on = 1'b1;
    run_phase(8'd39, 1'b0, 300, 30);
    run_phase(8'd255, 1'b1, 250, 15);
    run_phase(8'd1, 1'b0, 90, 25);
    // few reads: fill the ring and drop bytes on overflow
    run_phase(8'd157, 1'b0, 450, 2);
    run_phase(8'd78, 1'b0, 250, 45);
    run_phase(8'($urandom_range(255, 1)), 1'($urandom), 250, 20);

    wait_drained();
    repeat (10) @(posedge clk);
    if (track.errors == 0) begin
      $display("edge_timed_uart_receiver verification clean");
    end else begin
      $display("edge_timed_uart_receiver verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("edge_timed_uart_receiver verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/etur_pkg.sv
rtl/etur_front.sv
rtl/etur_back.sv
rtl/edge_timed_uart_receiver.sv
bench/edge_timed_uart_receiver_tb.sv
